// File: hdl/time_varying_all_pole_filter_core_defines.svh
// Assertion macros used by the checker of the all-pole filter core.
// This header has no dependencies.
`ifndef TIME_VARYING_ALL_POLE_FILTER_CORE_DEFINES_SVH
`define TIME_VARYING_ALL_POLE_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define TVAPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvapf check failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define TVAPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvapf check failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define TVAPF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tvapf check failed");

`endif

// File: hdl/tvapf_pkg.sv
// Types and constants of the time-varying all-pole filter core.
// This package has no dependencies; all other files but the defines header use it.
package tvapf_pkg;

   localparam int MaxOrder     = 8;
   localparam int SampleWidth  = 16;
   localparam int CoefWidth    = 16;
   localparam int CoefFracBits = 12;
   localparam int OrderWidth   = 4;
   localparam int ProdWidth    = SampleWidth + CoefWidth;
   localparam int AccWidth     = ProdWidth + $clog2(MaxOrder) + 2;
   localparam int ResWidth     = AccWidth - CoefFracBits;

   localparam logic [OrderWidth-1:0] OrderReset = OrderWidth'(MaxOrder);

   localparam logic signed [ResWidth-1:0] YMax = ResWidth'((2 ** (SampleWidth - 1)) - 1);
   localparam logic signed [ResWidth-1:0] YMin = -YMax - ResWidth'(1);
   localparam logic signed [AccWidth-1:0] RoundBias = AccWidth'(2 ** (CoefFracBits - 1));

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_FILTER = 1'b1
   } opcode_type;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [CoefWidth-1:0]   coef_type;
   typedef sample_type [MaxOrder-1:0]     hist_type;
   typedef logic [OrderWidth-1:0]         order_type;

   typedef struct packed {
      opcode_type opcode;
      sample_type sample;
      coef_type   coef_0;
      coef_type   coef_1;
      coef_type   coef_2;
      coef_type   coef_3;
      coef_type   coef_4;
      coef_type   coef_5;
      coef_type   coef_6;
      coef_type   coef_7;
   } req_type;

   typedef struct packed {
      sample_type filtered_sample;
      logic       saturated;
   } rsp_type;

endpackage

// File: hdl/tvapf_mac.sv
// Feedback multiply-accumulate, rounding and saturation of one filter item.
// Depends on tvapf_pkg.
module tvapf_mac (
   input  tvapf_pkg::req_type   item,
   input  tvapf_pkg::hist_type  history,
   input  tvapf_pkg::order_type active_order,
   output tvapf_pkg::rsp_type   result
);

   tvapf_pkg::coef_type coefs [tvapf_pkg::MaxOrder];
   logic signed [tvapf_pkg::ProdWidth-1:0] prods [tvapf_pkg::MaxOrder];
   logic signed [tvapf_pkg::AccWidth-1:0]  pair_sums [tvapf_pkg::MaxOrder/2];
   logic signed [tvapf_pkg::AccWidth-1:0]  quad_sums [tvapf_pkg::MaxOrder/4];
   logic signed [tvapf_pkg::AccWidth-1:0]  acc;
   logic signed [tvapf_pkg::AccWidth-1:0]  rounded;
   logic signed [tvapf_pkg::ResWidth-1:0]  scaled;

   assign coefs[0] = item.coef_0;
   assign coefs[1] = item.coef_1;
   assign coefs[2] = item.coef_2;
   assign coefs[3] = item.coef_3;
   assign coefs[4] = item.coef_4;
   assign coefs[5] = item.coef_5;
   assign coefs[6] = item.coef_6;
   assign coefs[7] = item.coef_7;

   always_comb begin
      for (int i = 0; i < tvapf_pkg::MaxOrder; i++) begin
         if (tvapf_pkg::OrderWidth'(i) < active_order) begin
            prods[i] = coefs[i] * history[i];
         end else begin
            prods[i] = '0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < tvapf_pkg::MaxOrder / 2; i++) begin
         pair_sums[i] = tvapf_pkg::AccWidth'(prods[2*i]) + tvapf_pkg::AccWidth'(prods[2*i+1]);
      end
      for (int i = 0; i < tvapf_pkg::MaxOrder / 4; i++) begin
         quad_sums[i] = pair_sums[2*i] + pair_sums[2*i+1];
      end
      acc = (tvapf_pkg::AccWidth'(item.sample) <<< tvapf_pkg::CoefFracBits)
          - (quad_sums[0] + quad_sums[1]);
   end

   assign rounded = acc + tvapf_pkg::RoundBias;
   assign scaled  = rounded[tvapf_pkg::AccWidth-1:tvapf_pkg::CoefFracBits];

   always_comb begin
      if (scaled > tvapf_pkg::YMax) begin
         result.filtered_sample = tvapf_pkg::SampleWidth'(tvapf_pkg::YMax);
         result.saturated       = 1'b1;
      end else if (scaled < tvapf_pkg::YMin) begin
         result.filtered_sample = tvapf_pkg::SampleWidth'(tvapf_pkg::YMin);
         result.saturated       = 1'b1;
      end else begin
         result.filtered_sample = scaled[tvapf_pkg::SampleWidth-1:0];
         result.saturated       = 1'b0;
      end
   end

endmodule

// File: hdl/time_varying_all_pole_filter_core.sv
// An accepted item is registered in the stage register, a filter result in the result
// register when the stage advances. One item per cycle unless the result port stalls;
// each item's multiply-accumulate stage feeds the output history that the next item reads.
// Load items update the history and give no result.
// Synchronous active-high reset empties both registers, zeroes the history and
// sets the active order to eight.
module time_varying_all_pole_filter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tvapf_pkg::req_type   req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tvapf_pkg::rsp_type   rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  tvapf_pkg::order_type csr_data
);

   logic                 stage_valid_ff, stage_valid_in;
   tvapf_pkg::req_type   stage_item_ff, stage_item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tvapf_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   tvapf_pkg::hist_type  history_ff, history_in;
   tvapf_pkg::order_type active_order_ff, active_order_in;
   tvapf_pkg::rsp_type   mac_result;
   logic                 is_load;
   logic                 advance;

   tvapf_mac u_mac (
      .item         (stage_item_ff),
      .history      (history_ff),
      .active_order (active_order_ff),
      .result       (mac_result)
   );

   assign is_load   = (stage_item_ff.opcode == tvapf_pkg::OP_LOAD);
   assign advance   = stage_valid_ff && (is_load || !rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      stage_valid_in  = stage_valid_ff;
      stage_item_in   = stage_item_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_item_in     = rsp_item_ff;
      history_in      = history_ff;
      active_order_in = active_order_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
         stage_item_in  = req_item;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         history_in = {history_ff[tvapf_pkg::MaxOrder-2:0],
                       is_load ? stage_item_ff.sample : mac_result.filtered_sample};
         if (!is_load) begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = mac_result;
         end
      end
      if (csr_valid) begin
         active_order_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         history_ff      <= '0;
         active_order_ff <= tvapf_pkg::OrderReset;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         history_ff      <= history_in;
         active_order_ff <= active_order_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
      rsp_item_ff   <= rsp_item_in;
   end

endmodule

// File: hdl/tvapf_checker.sv
// Port-level checks of the all-pole filter core, bound to the top level.
// Depends on tvapf_pkg and time_varying_all_pole_filter_core_defines.svh.
`include "time_varying_all_pole_filter_core_defines.svh"

module tvapf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input tvapf_pkg::req_type   req_item,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tvapf_pkg::rsp_type   rsp_item,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   logic filter_accept;
   logic rsp_stalled;
   logic sat_value;

   assign filter_accept = req_valid && req_ready
                       && (req_item.opcode == tvapf_pkg::OP_FILTER);
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign sat_value = (rsp_item.filtered_sample == tvapf_pkg::SampleWidth'(tvapf_pkg::YMax))
                   || (rsp_item.filtered_sample == tvapf_pkg::SampleWidth'(tvapf_pkg::YMin));

   `TVAPF_ASSERT_ALWAYS_NEXT(a_reset_empties_output, clock, reset, !rsp_valid)
   `TVAPF_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_item))
   `TVAPF_ASSERT_SAME(a_saturated_at_limit, clock, reset, rsp_valid && rsp_item.saturated, sat_value)
   `TVAPF_ASSERT_NEXT(a_filter_gives_output, clock, reset, filter_accept, ##1 rsp_valid)
   `TVAPF_ASSERT_SAME(a_csr_always_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind time_varying_all_pole_filter_core tvapf_checker u_tvapf_checker (.*);

// File: sim/time_varying_all_pole_filter_core_test.sv
// Self-checking testbench for the time-varying all-pole filter core: a table of directed
// items, then random items, checked against an in-bench filter that tracks the history.
// Depends on tvapf_pkg and the time_varying_all_pole_filter_core RTL.
module time_varying_all_pole_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tvapf_pkg::*;

   localparam int     WatchdogLimit = 2000;
   localparam int     SettleCycles  = 4;
   localparam int     PhaseItems    = 250;
   localparam longint SampleMax     = (longint'(1) <<< (SampleWidth - 1)) - 1;
   localparam longint SampleMin     = -SampleMax - 1;

   typedef enum bit {
      ROW_ITEM,
      ROW_ORDER
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      order_type    order;
      opcode_type   opcode;
      sample_type   sample;
      coef_type     lead;
      coef_type     rest;
      bit           checked;
      rsp_type      result;
   } stim_row_type;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   req_type   req_item  = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   rsp_type   rsp_item;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   order_type csr_data  = '0;

   sample_type   history [MaxOrder];
   order_type    order_setting;
   rsp_type      future_outputs [$];
   bit           typed_check;
   rsp_type      typed_result;
   int           mismatch_count = 0;
   int           stall_cycles = 0;
   int           req_idle_pct = 25;
   int           rsp_idle_pct = 25;
   stim_row_type directed_rows [21];

   time_varying_all_pole_filter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Runs one item through the filter; load items only shift the history.
   function automatic rsp_type synthesize_sample(input req_type item);
      coef_type coefs [MaxOrder];
      longint   acc;
      longint   y;
      int       taps;
      rsp_type  res;
      coefs = '{item.coef_0, item.coef_1, item.coef_2, item.coef_3,
                item.coef_4, item.coef_5, item.coef_6, item.coef_7};
      res = '0;
      if (item.opcode == OP_LOAD) begin
         y = item.sample;
      end else begin
         taps = (order_setting > MaxOrder) ? MaxOrder : int'(order_setting);
         acc = longint'(item.sample) <<< CoefFracBits;
         for (int i = 0; i < taps; i++) begin
            acc -= longint'(coefs[i]) * longint'(history[i]);
         end
         acc += longint'(1) <<< (CoefFracBits - 1);
         y = acc >>> CoefFracBits;
         if (y > SampleMax) begin
            y = SampleMax;
            res.saturated = 1'b1;
         end
         if (y < SampleMin) begin
            y = SampleMin;
            res.saturated = 1'b1;
         end
      end
      for (int i = MaxOrder - 1; i > 0; i--) begin
         history[i] = history[i - 1];
      end
      history[0] = sample_type'(y);
      res.filtered_sample = sample_type'(y);
      return res;
   endfunction

   function automatic coef_type random_coef();
      case ($urandom_range(0, 7))
         0: begin
            return coef_type'($urandom);
         end
         1: begin
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         end
         default: begin
            return coef_type'(int'($urandom_range(0, 1023)) - 512);
         end
      endcase
   endfunction

   function automatic req_type random_request();
      req_type item;
      item.opcode = ($urandom_range(0, 4) == 0) ? OP_LOAD : OP_FILTER;
      case ($urandom_range(0, 7))
         0: begin
            item.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         end
         1: begin
            item.sample = sample_type'(int'($urandom_range(0, 255)) - 128);
         end
         default: begin
            item.sample = sample_type'($urandom);
         end
      endcase
      item.coef_0 = random_coef();
      item.coef_1 = random_coef();
      item.coef_2 = random_coef();
      item.coef_3 = random_coef();
      item.coef_4 = random_coef();
      item.coef_5 = random_coef();
      item.coef_6 = random_coef();
      item.coef_7 = random_coef();
      return item;
   endfunction

   task automatic drive_request(input req_type item, input bit checked, input rsp_type result);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      typed_check = checked;
      typed_result = result;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // The order register is only written once the filter has drained.
   task automatic write_order(input order_type value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (future_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type wanted;
      rsp_type predicted;
      if (reset) begin
         foreach (history[i]) begin
            history[i] = '0;
         end
         order_setting = order_type'(MaxOrder);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (future_outputs.size() == 0) begin
               report_mismatch("result item with no expected output");
            end else begin
               wanted = future_outputs.pop_front();
               if (rsp_item.filtered_sample !== wanted.filtered_sample) begin
                  report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                     rsp_item.filtered_sample, wanted.filtered_sample));
               end
               if (rsp_item.saturated !== wanted.saturated) begin
                  report_mismatch($sformatf("saturated %0b, expected %0b",
                     rsp_item.saturated, wanted.saturated));
               end
            end
         end
         if (req_valid && req_ready) begin
            predicted = synthesize_sample(req_item);
            if (req_item.opcode == OP_FILTER) begin
               future_outputs.push_back(typed_check ? typed_result : predicted);
            end
         end
         if (csr_valid && csr_ready) begin
            order_setting = csr_data;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_type   item;
      order_type phase_orders [5];
      phase_orders = '{4'd3, 4'd0, 4'd15, 4'd8, 4'd1};
      directed_rows = '{
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh1234, 16'sh7fff, 16'sh7fff, 1'b1, '{16'sh1234, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1, '{16'sh8000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_LOAD,   16'sh7fff, 16'shffff, 16'shffff, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_LOAD,   16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b1, '{16'sh7fff, 1'b1}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh8000, 16'sh7fff, 16'sh0000, 1'b1, '{16'sh8000, 1'b1}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh0100, 16'sh0400, 16'shfe00, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ORDER, 4'd0,  OP_LOAD,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, '{16'sh7fff, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, '{16'sh8000, 1'b0}},
         '{ROW_ORDER, 4'd15, OP_LOAD,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh4000, 16'sh0200, 16'shff00, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ORDER, 4'd1,  OP_LOAD,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_LOAD,   16'sh0001, 16'sh5555, 16'shaaaa, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh0000, 16'shf800, 16'sh7fff, 1'b1, '{16'sh0001, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh0000, 16'sh0800, 16'sh8000, 1'b1, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh2000, 16'sh1000, 16'sh7fff, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ORDER, 4'd9,  OP_LOAD,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'shc000, 16'shf000, 16'sh0100, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ORDER, 4'd8,  OP_LOAD,   16'sh0000, 16'sh0000, 16'sh0000, 1'b0, '{16'sh0000, 1'b0}},
         '{ROW_ITEM,  4'd0,  OP_FILTER, 16'sh0800, 16'shf000, 16'shfc00, 1'b0, '{16'sh0000, 1'b0}}
      };
      typed_check = 1'b0;
      typed_result = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_ORDER) begin
            write_order(directed_rows[n].order);
         end else begin
            item.opcode = directed_rows[n].opcode;
            item.sample = directed_rows[n].sample;
            item.coef_0 = directed_rows[n].lead;
            item.coef_1 = directed_rows[n].rest;
            item.coef_2 = directed_rows[n].rest;
            item.coef_3 = directed_rows[n].rest;
            item.coef_4 = directed_rows[n].rest;
            item.coef_5 = directed_rows[n].rest;
            item.coef_6 = directed_rows[n].rest;
            item.coef_7 = directed_rows[n].rest;
            drive_request(item, directed_rows[n].checked, directed_rows[n].result);
         end
      end

      for (int phase = 0; phase < 7; phase++) begin
         write_order(phase < 5 ? phase_orders[phase] : order_type'($urandom_range(0, 15)));
         req_idle_pct = (phase == 3) ? 0 : 25;
         rsp_idle_pct = (phase == 3) ? 0 : 25;
         repeat (PhaseItems) drive_request(random_request(), 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (future_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
